FILE: design/ctcg_pkg.sv
// Package for the cylinder texture coordinate generator.
// Holds the payload structs, register indexes, the arctangent table and the
// divider and rotation step functions; it depends on nothing else.
package ctcg_pkg;

  localparam int ATAN_ITERATIONS_DEF = 16;
  localparam int TABLE_LEN = 24;
  localparam int DIV_STEPS = 16;
  localparam int CW = 34;
  localparam int SUM_W = 36;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MIN_Z = 3'd2;
  localparam logic [2:0] REG_MAX_X = 3'd3;
  localparam logic [2:0] REG_MAX_Y = 3'd4;
  localparam logic [2:0] REG_MAX_Z = 3'd5;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } in_t;

  typedef struct packed {
    logic [16:0] tex_s;
    logic [16:0] tex_t;
    logic        on_cap;
  } out_t;

  typedef struct packed {
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] min_z;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic signed [15:0] max_z;
  } box_t;

  // Magnitudes of the offset from the minimum and the extent, with the sign of the quotient.
  typedef struct packed {
    logic [15:0] num;
    logic [15:0] den;
    logic        neg;
    logic        flip;
  } div_job_t;

  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] den;
    logic [16:0] quo;
    logic        ovf;
    logic        neg;
    logic        flip;
  } div_st_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] ang;
    logic                 origin;
  } cordic_st_t;

  typedef struct packed {
    logic       on_cap;
    cordic_st_t cs;
    div_job_t   ds;
    div_job_t   dt;
  } job_t;

  function automatic logic signed [CW-1:0] atan_turn(input logic [4:0] idx);
    logic signed [CW-1:0] r;
    case (idx)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // A zero extent counts as 1.0 in Q7.8.
  function automatic div_job_t mk_div(input logic signed [15:0] p,
                                      input logic signed [15:0] lo,
                                      input logic signed [15:0] hi,
                                      input logic flip);
    logic signed [16:0] diff;
    logic signed [16:0] ext;
    logic [16:0] an;
    logic [16:0] ad;
    div_job_t r;
    diff = 17'(p) - 17'(lo);
    ext = 17'(hi) - 17'(lo);
    if (ext == '0) begin
      ext = 17'sd256;
    end
    an = diff[16] ? 17'(-diff) : 17'(diff);
    ad = ext[16] ? 17'(-ext) : 17'(ext);
    r.num = an[15:0];
    r.den = ad[15:0];
    r.neg = diff[16] ^ ext[16];
    r.flip = flip;
    return r;
  endfunction

  // Integer bit of the quotient; anything above one saturates anyway.
  function automatic div_st_t div_init(input div_job_t j);
    div_st_t r;
    logic ge;
    ge = j.num >= j.den;
    r.ovf = j.num > j.den;
    r.rem = ge ? 17'(j.num - j.den) : 17'(j.num);
    r.quo = {16'd0, ge};
    r.den = j.den;
    r.neg = j.neg;
    r.flip = j.flip;
    return r;
  endfunction

  function automatic div_st_t div_step(input div_st_t s);
    div_st_t r;
    logic [16:0] r2;
    logic ge;
    r = s;
    r2 = {s.rem[15:0], 1'b0};
    ge = r2 >= 17'(s.den);
    r.rem = ge ? 17'(r2 - 17'(s.den)) : r2;
    r.quo = {s.quo[15:0], ge};
    return r;
  endfunction

  function automatic logic [16:0] div_final(input div_st_t s);
    logic [16:0] r;
    if (!s.flip) begin
      if (s.neg && s.quo != '0) begin
        r = '0;
      end else if (s.ovf) begin
        r = ONE_Q16;
      end else begin
        r = s.quo;
      end
    end else begin
      if (s.neg) begin
        r = ONE_Q16;
      end else if (s.ovf) begin
        r = '0;
      end else begin
        r = 17'(ONE_Q16 - s.quo);
      end
    end
    return r;
  endfunction

  function automatic cordic_st_t cordic_init(input logic signed [15:0] px,
                                             input logic signed [15:0] pz);
    cordic_st_t r;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    x0 = CW'(pz) <<< 14;
    y0 = CW'(px) <<< 14;
    r.origin = (px == '0) && (pz == '0);
    if (x0 < 0) begin
      r.ang = (y0 >= 0) ? 34'sd2147483648 : -34'sd2147483648;
      r.x = -x0;
      r.y = -y0;
    end else begin
      r.ang = '0;
      r.x = x0;
      r.y = y0;
    end
    return r;
  endfunction

  function automatic cordic_st_t cordic_step(input cordic_st_t s, input int i);
    cordic_st_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    r = s;
    xs = s.x >>> i;
    ys = s.y >>> i;
    if (s.y >= 0) begin
      r.x = s.x + ys;
      r.y = s.y - xs;
      r.ang = s.ang + atan_turn(5'(i));
    end else begin
      r.x = s.x - ys;
      r.y = s.y + xs;
      r.ang = s.ang - atan_turn(5'(i));
    end
    return r;
  endfunction

  function automatic logic [16:0] angle_final(input cordic_st_t s);
    logic signed [SUM_W-1:0] sum;
    logic [16:0] r;
    sum = SUM_W'(s.ang) + 36'sd2147483648 + 36'sd32768;
    if (s.origin) begin
      r = HALF_Q16;
    end else if (sum < 0) begin
      r = '0;
    end else if ((sum >>> 16) > SUM_W'(ONE_Q16)) begin
      r = ONE_Q16;
    end else begin
      r = sum[32:16];
    end
    return r;
  endfunction

endpackage

FILE: design/cylinder_texture_coord_gen_core.sv
// Top level of the cylinder texture coordinate generator: bounding box
// registers on the APB-style port, front end, queue and back end. Depends on ctcg_pkg.
//
// One vertex is taken each clock while busy is low; busy only rises if the
// queue between the front and back ends fills, which does not happen since
// the back end advances every cycle. Each transaction yields one coordinate
// on coord with done high for one cycle, after the front end register, the
// queue, the rotation and divider pipeline and the output register. The
// receiver cannot stall results, so it must take every cycle that done is high.
module cylinder_texture_coord_gen_core #(
  parameter int ATAN_ITERATIONS = ctcg_pkg::ATAN_ITERATIONS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ctcg_pkg::in_t   vertex,
  output logic            done,
  output ctcg_pkg::out_t  coord,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  ctcg_pkg::box_t box;
  ctcg_pkg::job_t front_job;
  ctcg_pkg::job_t back_job;
  logic front_valid;
  logic queue_ready;
  logic back_valid;
  logic wr_en;
  logic [2:0] reg_idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      box.min_x <= 16'sd0;
      box.min_y <= 16'sd0;
      box.min_z <= 16'sd0;
      box.max_x <= 16'sd256;
      box.max_y <= 16'sd256;
      box.max_z <= 16'sd256;
    end else if (wr_en) begin
      case (reg_idx)
        ctcg_pkg::REG_MIN_X: box.min_x <= pwdata[15:0];
        ctcg_pkg::REG_MIN_Y: box.min_y <= pwdata[15:0];
        ctcg_pkg::REG_MIN_Z: box.min_z <= pwdata[15:0];
        ctcg_pkg::REG_MAX_X: box.max_x <= pwdata[15:0];
        ctcg_pkg::REG_MAX_Y: box.max_y <= pwdata[15:0];
        ctcg_pkg::REG_MAX_Z: box.max_z <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ctcg_pkg::REG_MIN_X: prdata = {16'd0, box.min_x};
      ctcg_pkg::REG_MIN_Y: prdata = {16'd0, box.min_y};
      ctcg_pkg::REG_MIN_Z: prdata = {16'd0, box.min_z};
      ctcg_pkg::REG_MAX_X: prdata = {16'd0, box.max_x};
      ctcg_pkg::REG_MAX_Y: prdata = {16'd0, box.max_y};
      ctcg_pkg::REG_MAX_Z: prdata = {16'd0, box.max_z};
      default: prdata = '0;
    endcase
  end

  ctcg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .vertex    (vertex),
    .box       (box),
    .job_valid (front_valid),
    .job       (front_job),
    .job_ready (queue_ready)
  );

  ctcg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_valid),
    .push_job   (front_job),
    .push_ready (queue_ready),
    .pop_valid  (back_valid),
    .pop_job    (back_job)
  );

  ctcg_back #(
    .ATAN_ITERATIONS (ATAN_ITERATIONS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (back_valid),
    .job       (back_job),
    .done      (done),
    .coord     (coord)
  );

endmodule

FILE: design/ctcg_front.sv
// Front end: takes a vertex, picks the dominant normal axis and sets up the
// rotation and division operands. Depends on ctcg_pkg.
module ctcg_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ctcg_pkg::in_t   vertex,
  input  ctcg_pkg::box_t  box,
  output logic            job_valid,
  output ctcg_pkg::job_t  job,
  input  logic            job_ready
);

  ctcg_pkg::job_t job_next;
  logic [16:0] ax;
  logic [16:0] ay;
  logic [16:0] az;
  logic cap;
  logic accept;

  always_comb begin
    ax = vertex.normal_x[15] ? -17'(vertex.normal_x) : 17'(vertex.normal_x);
    ay = vertex.normal_y[15] ? -17'(vertex.normal_y) : 17'(vertex.normal_y);
    az = vertex.normal_z[15] ? -17'(vertex.normal_z) : 17'(vertex.normal_z);
    // y wins only when it beats x strictly and z does not beat it.
    cap = (ay > ax) && !(az > ay);
    job_next.on_cap = cap;
    job_next.cs = ctcg_pkg::cordic_init(vertex.point_x, vertex.point_z);
    job_next.ds = ctcg_pkg::mk_div(vertex.point_x, box.min_x, box.max_x, 1'b0);
    if (cap) begin
      job_next.dt = ctcg_pkg::mk_div(vertex.point_z, box.min_z, box.max_z,
                                     (vertex.normal_y > 0));
    end else begin
      job_next.dt = ctcg_pkg::mk_div(vertex.point_y, box.min_y, box.max_y, 1'b0);
    end
  end

  assign busy = job_valid && !job_ready;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= 1'b1;
    end else if (job_ready) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

FILE: design/ctcg_queue.sv
// Two-entry queue of classified vertices between the front and back ends.
// Depends on ctcg_pkg.
module ctcg_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ctcg_pkg::job_t  push_job,
  output logic            push_ready,
  output logic            pop_valid,
  output ctcg_pkg::job_t  pop_job
);

  ctcg_pkg::job_t mem [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic do_push;
  logic do_pop;

  // The back end never stalls, so every held entry leaves at once.
  assign pop_valid = count != 2'd0;
  assign do_pop = pop_valid;
  assign push_ready = (count != 2'd2) || do_pop;
  assign do_push = push && push_ready;
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= 2'(count + 2'(do_push) - 2'(do_pop));
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: design/ctcg_back.sv
// Back end: pipelined arctangent rotation and two restoring dividers, one
// step per stage, then saturation into the output register. Depends on ctcg_pkg.
module ctcg_back #(
  parameter int ATAN_ITERATIONS = ctcg_pkg::ATAN_ITERATIONS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  ctcg_pkg::job_t  job,
  output logic            done,
  output ctcg_pkg::out_t  coord
);

  localparam int ITER = (ATAN_ITERATIONS < ctcg_pkg::TABLE_LEN) ?
                        ATAN_ITERATIONS : ctcg_pkg::TABLE_LEN;
  localparam int NST = (ITER > ctcg_pkg::DIV_STEPS) ? ITER : ctcg_pkg::DIV_STEPS;

  logic [NST:0] vld;
  logic [NST:0] cap;
  ctcg_pkg::cordic_st_t cs [NST+1];
  ctcg_pkg::div_st_t ds [NST+1];
  ctcg_pkg::div_st_t dt [NST+1];
  ctcg_pkg::out_t coord_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NST-1:0], job_valid};
    end
  end

  always_ff @(posedge clk) begin
    cap[0] <= job.on_cap;
    cs[0] <= job.cs;
    ds[0] <= ctcg_pkg::div_init(job.ds);
    dt[0] <= ctcg_pkg::div_init(job.dt);
    for (int k = 0; k < NST; k++) begin
      cap[k+1] <= cap[k];
      if (k < ITER) begin
        cs[k+1] <= ctcg_pkg::cordic_step(cs[k], k);
      end else begin
        cs[k+1] <= cs[k];
      end
      if (k < ctcg_pkg::DIV_STEPS) begin
        ds[k+1] <= ctcg_pkg::div_step(ds[k]);
        dt[k+1] <= ctcg_pkg::div_step(dt[k]);
      end else begin
        ds[k+1] <= ds[k];
        dt[k+1] <= dt[k];
      end
    end
  end

  always_comb begin
    coord_next.on_cap = cap[NST];
    coord_next.tex_s = cap[NST] ? ctcg_pkg::div_final(ds[NST]) :
                                  ctcg_pkg::angle_final(cs[NST]);
    coord_next.tex_t = ctcg_pkg::div_final(dt[NST]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[NST];
    end
  end

  always_ff @(posedge clk) begin
    coord <= coord_next;
  end

endmodule
